// File: design/socd_pkg.sv
// ----------------------------------------------------------------------------
// socd_pkg
// shared types and constants for the opposite-direction key cleaner
// ----------------------------------------------------------------------------
package socd_pkg;

   localparam int unsigned KEY_W    = 8;
   localparam int unsigned NUM_DIRS = 4;
   localparam int unsigned DIR_W    = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // direction slots
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

   // flipping the low bit of a direction gives its opposite
   localparam logic [DIR_W-1:0] DIR_OPPOSITE_MASK = 2'd1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_KEY       = 3'd0,
      CSR_RIGHT_KEY      = 3'd1,
      CSR_UP_KEY         = 3'd2,
      CSR_DOWN_KEY       = 3'd3,
      CSR_BYPASS_KEY     = 3'd4,
      CSR_ESCAPE_SRC_KEY = 3'd5
   } csr_index_type;

   // reset key bindings
   localparam logic [KEY_W-1:0] RESET_LEFT_KEY       = 8'h41;
   localparam logic [KEY_W-1:0] RESET_RIGHT_KEY      = 8'h44;
   localparam logic [KEY_W-1:0] RESET_UP_KEY         = 8'h57;
   localparam logic [KEY_W-1:0] RESET_DOWN_KEY       = 8'h53;
   localparam logic [KEY_W-1:0] RESET_BYPASS_KEY     = 8'h45;
   localparam logic [KEY_W-1:0] RESET_ESCAPE_SRC_KEY = 8'h00;

   // escape binding of zero means unbound
   localparam logic [KEY_W-1:0] KEY_UNBOUND = 8'h00;

   typedef logic [NUM_DIRS-1:0][KEY_W-1:0] key_map_type;

   typedef struct packed {
      logic             hit;
      logic [DIR_W-1:0] idx;
   } dir_match_type;

   typedef struct packed {
      logic             inject_valid;
      logic             inject_escape;
      logic [KEY_W-1:0] inject_key;
      logic             inject_release;
   } rsp_type;

   // first matching direction in order left, right, up, down
   function automatic dir_match_type dir_of(input logic [KEY_W-1:0] code,
                                            input key_map_type keys);
      dir_match_type m;
      m.hit = 1'b1;
      if (code == keys[DIR_LEFT]) begin
         m.idx = DIR_LEFT;
      end else if (code == keys[DIR_RIGHT]) begin
         m.idx = DIR_RIGHT;
      end else if (code == keys[DIR_UP]) begin
         m.idx = DIR_UP;
      end else if (code == keys[DIR_DOWN]) begin
         m.idx = DIR_DOWN;
      end else begin
         m.hit = 1'b0;
         m.idx = DIR_LEFT;
      end
      return m;
   endfunction

endpackage

// File: design/socd_last_input_priority_cleaner.sv
// ----------------------------------------------------------------------------
// socd_last_input_priority_cleaner
// resolves opposite direction keys by last-input priority, one key event a beat
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  key_code, is_press, is_injected
//   rsp      out        rsp_valid / rsp_ready  inject_valid, inject_escape,
//                                              inject_key, inject_release
//   csr      in         csr_valid / csr_ready  index, data (write only)
//
// one beat a cycle while the rsp side is not stalled: the held-key state is updated and the result computed by a
//   few key-code compares in the cycle the req beat is accepted
// the result is registered, so rsp_valid rises in the cycle after the req beat is accepted
// req_ready stays high while the result register is empty or being drained,
//   so a stalled rsp side holds off only the next beat
// synchronous reset restores the default key bindings and clears all held bits
// csr writes are always taken; csr_ready is tied high
//
module socd_last_input_priority_cleaner
   import socd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KEY_W-1:0]     req_key_code,
   input  logic                 req_is_press,
   input  logic                 req_is_injected,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_inject_valid,
   output logic                 rsp_inject_escape,
   output logic [KEY_W-1:0]     rsp_inject_key,
   output logic                 rsp_inject_release,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_data
);

   // key bindings
   key_map_type      dir_keys_ff;
   logic [KEY_W-1:0] bypass_key_ff;
   logic [KEY_W-1:0] escape_key_ff;

   // held-key state
   logic [NUM_DIRS-1:0] physical_held_ff, physical_held_in;
   logic [NUM_DIRS-1:0] reported_held_ff, reported_held_in;
   logic                bypass_held_ff,   bypass_held_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic req_accept;
   logic csr_accept;

   // event decode
   dir_match_type       ev_dir;
   logic [KEY_W-1:0]    opp_key;
   dir_match_type       opp_dir;
   logic [NUM_DIRS-1:0] ev_bit;
   logic [NUM_DIRS-1:0] opp_bit;
   logic [NUM_DIRS-1:0] phys_upd;
   logic [NUM_DIRS-1:0] rep_upd;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // skid via result register: take a new beat whenever it is empty or the old result leaves
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_keys_ff[DIR_LEFT]  <= RESET_LEFT_KEY;
         dir_keys_ff[DIR_RIGHT] <= RESET_RIGHT_KEY;
         dir_keys_ff[DIR_UP]    <= RESET_UP_KEY;
         dir_keys_ff[DIR_DOWN]  <= RESET_DOWN_KEY;
         bypass_key_ff          <= RESET_BYPASS_KEY;
         escape_key_ff          <= RESET_ESCAPE_SRC_KEY;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_LEFT_KEY:       dir_keys_ff[DIR_LEFT]  <= csr_data;
            CSR_RIGHT_KEY:      dir_keys_ff[DIR_RIGHT] <= csr_data;
            CSR_UP_KEY:         dir_keys_ff[DIR_UP]    <= csr_data;
            CSR_DOWN_KEY:       dir_keys_ff[DIR_DOWN]  <= csr_data;
            CSR_BYPASS_KEY:     bypass_key_ff          <= csr_data;
            CSR_ESCAPE_SRC_KEY: escape_key_ff          <= csr_data;
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // direction of the event and of its opposite; the opposite's key is looked
   // up again so duplicate bindings resolve to the first matching slot
   always_comb begin
      ev_dir  = dir_of(req_key_code, dir_keys_ff);
      opp_key = dir_keys_ff[ev_dir.idx ^ DIR_OPPOSITE_MASK];
      opp_dir = dir_of(opp_key, dir_keys_ff);
      ev_bit  = NUM_DIRS'(1) << ev_dir.idx;
      opp_bit = NUM_DIRS'(1) << opp_dir.idx;
   end

   // next state and result for the beat at the req port
   always_comb begin
      physical_held_in = physical_held_ff;
      reported_held_in = reported_held_ff;
      bypass_held_in   = bypass_held_ff;
      rsp_in           = '0;
      phys_upd         = physical_held_ff;
      rep_upd          = reported_held_ff;

      if (req_is_injected) begin
         // synthetic events leave everything alone
      end else if (req_key_code == bypass_key_ff) begin
         bypass_held_in = req_is_press;
      end else if (escape_key_ff != KEY_UNBOUND && req_key_code == escape_key_ff) begin
         rsp_in.inject_valid   = 1'b1;
         rsp_in.inject_escape  = 1'b1;
         rsp_in.inject_release = !req_is_press;
      end else if (ev_dir.hit) begin
         if (req_is_press) begin
            phys_upd = physical_held_ff | ev_bit;
            rep_upd  = reported_held_ff | ev_bit;
            // newest press wins: drop the opposite if it is still reported, unless bypass is held
            if ((phys_upd & opp_bit) != '0 && (rep_upd & opp_bit) != '0
                && !bypass_held_ff) begin
               rsp_in.inject_valid   = 1'b1;
               rsp_in.inject_key     = opp_key;
               rsp_in.inject_release = 1'b1;
               rep_upd               = rep_upd & ~opp_bit;
            end
         end else begin
            phys_upd = physical_held_ff & ~ev_bit;
            rep_upd  = reported_held_ff & ~ev_bit;
            // opposite still physically down and bypass not held: report it pressed again
            if ((phys_upd & opp_bit) != '0 && !bypass_held_ff) begin
               rsp_in.inject_valid = 1'b1;
               rsp_in.inject_key   = opp_key;
               rep_upd             = rep_upd | opp_bit;
            end
         end
         physical_held_in = phys_upd;
         reported_held_in = rep_upd;
      end
   end

   // held-key state advances only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         physical_held_ff <= '0;
         reported_held_ff <= '0;
         bypass_held_ff   <= 1'b0;
      end else if (req_accept) begin
         physical_held_ff <= physical_held_in;
         reported_held_ff <= reported_held_in;
         bypass_held_ff   <= bypass_held_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inject_valid   = rsp_ff.inject_valid;
   assign rsp_inject_escape  = rsp_ff.inject_escape;
   assign rsp_inject_key     = rsp_ff.inject_key;
   assign rsp_inject_release = rsp_ff.inject_release;

`ifndef NO_ASSERTIONS
   // a direction is never reported held unless it is physically held
   a_reported_within_physical: assert property (@(posedge clock) disable iff (reset)
      (reported_held_ff & ~physical_held_ff) == '0)
      else $error("reported held bit without physical held bit");

   // injected beats leave the direction state untouched
   a_injected_no_state: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_is_injected |=>
         $stable(physical_held_ff) && $stable(reported_held_ff)
         && $stable(bypass_held_ff))
      else $error("injected beat changed held state");

   // every accepted beat leaves a result behind
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");
`endif

endmodule
